// File: hw/rtl/rbe_pkg.sv
// Package for the RTT and bandwidth estimator: item types, ring size,
// default estimates, op codes and divider widths.
// No dependencies.
package rbe_pkg;

   localparam int SAMPLES = 8;
   localparam int IDX_W   = $clog2(SAMPLES);

   localparam int DIVIDEND_W = 56;
   localparam int DIVISOR_W  = 48;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [31:0] RTT_DEFAULT = 32'd100_000_000;
   localparam logic [55:0] BW_DEFAULT  = 56'd1_000_000;
   // bytes to bits, then microseconds to seconds
   localparam logic [22:0] BW_SCALE    = 23'd8_000_000;

   localparam logic [1:0] OP_RTT   = 2'd0;
   localparam logic [1:0] OP_THRU  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] rtt_us;
      logic [31:0] byte_count;
      logic [47:0] timestamp_us;
   } req_type;

   typedef struct packed {
      logic [31:0] srtt_us;
      logic [55:0] bandwidth_bps;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_res_type;

endpackage

// File: hw/rtl/rtt_bandwidth_estimator_unit.sv
// RTT and bandwidth estimator, top level.
// Depends on rbe_pkg and rbe_divider.
//
// Each accepted item optionally records an RTT sample (op 0) or a
// throughput sample (op 1, byte count plus 48-bit timestamp) into rings of
// rbe_pkg::SAMPLES slots, then returns one item with two estimates. The
// smoothed RTT is a 7/8 moving average walked over the whole RTT ring from
// slot 0, or 100000000 us before any RTT sample. The bandwidth is the sum of
// the two newest byte counts times 8e6 over their timestamp difference
// modulo 2^48, or 1000000 bps while fewer than two RTT samples exist or the
// difference is zero. req_stall is high from acceptance until the result is
// loaded into the output register. After acceptance an item walks the whole
// RTT ring through one shared average step, fetches both throughput slots
// and forms the numerator, and, when a division is needed, goes around the
// bit-serial divider (a start state, 56 quotient bits, then picking up the
// quotient); it then loads the output register, and the next item can be
// accepted as soon as the result is loaded. A result still held in the
// output register by rsp_stall delays the load for as long as it waits.
// A finished result waits in the output register while the next item is
// already accepted. Reset clears all rings to zero at once.
module rtt_bandwidth_estimator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbe_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbe_pkg::rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMA,
      ST_NEWEST,
      ST_OLDER,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic [rbe_pkg::IDX_W-1:0] LAST_IDX = rbe_pkg::IDX_W'(rbe_pkg::SAMPLES - 1);

   state_type state_ff;

   // sample rings
   logic [31:0] rtt_ring_ff   [rbe_pkg::SAMPLES];
   logic [31:0] bytes_ring_ff [rbe_pkg::SAMPLES];
   logic [47:0] time_ring_ff  [rbe_pkg::SAMPLES];
   logic [rbe_pkg::IDX_W-1:0] rtt_pos_ff;
   logic [rbe_pkg::IDX_W-1:0] bw_pos_ff;
   logic [1:0]                rtt_seen_ff;

   // working registers
   logic [rbe_pkg::IDX_W-1:0] idx_ff;
   logic [31:0]               ema_ff;
   logic [31:0]               bytes_a_ff;
   logic [47:0]               time_a_ff;
   logic [32:0]               bsum_ff;
   logic [47:0]               dt_ff;
   logic [55:0]               num_ff;
   logic [55:0]               bw_ff;
   logic                      rsp_valid_ff;
   rbe_pkg::rsp_type          rsp_ff;

   logic                      accept;
   logic [rbe_pkg::IDX_W-1:0] newest;
   logic [rbe_pkg::IDX_W-1:0] older;
   logic [35:0]               ema_sum;
   logic [31:0]               ema_in;
   logic [55:0]               num_in;
   logic                      bw_default;
   logic                      out_free;

   rbe_pkg::div_cmd_type div_cmd;
   rbe_pkg::div_res_type div_res;

   function automatic logic [rbe_pkg::IDX_W-1:0] prev_idx(
      input logic [rbe_pkg::IDX_W-1:0] idx
   );
      // step back one slot, wrap to the top of the ring
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   function automatic logic [rbe_pkg::IDX_W-1:0] next_idx(
      input logic [rbe_pkg::IDX_W-1:0] idx
   );
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   always_comb begin
      accept  = (state_ff == ST_IDLE) && req_valid;
      newest  = prev_idx(bw_pos_ff);
      older   = prev_idx(newest);
      // s = (7*s + ring[i]) >> 3, with 7*s formed as 8*s - s
      ema_sum = ({1'b0, ema_ff, 3'b000} - {4'b0000, ema_ff})
                + {4'b0000, rtt_ring_ff[idx_ff]};
      ema_in  = ema_sum[34:3];
      num_in  = 56'(bsum_ff) * 56'(rbe_pkg::BW_SCALE);
      bw_default = (rtt_seen_ff < 2'd2) || (dt_ff == '0);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign div_cmd.start    = (state_ff == ST_START);
   assign div_cmd.dividend = num_ff;
   assign div_cmd.divisor  = dt_ff;

   rbe_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rtt_pos_ff   <= '0;
         bw_pos_ff    <= '0;
         rtt_seen_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rbe_pkg::SAMPLES; i++) begin
            rtt_ring_ff[i]   <= '0;
            bytes_ring_ff[i] <= '0;
            time_ring_ff[i]  <= '0;
         end
      end else begin
         // load a finished item, hold a stalled one, drop it once it is taken
         rsp_valid_ff <= ((state_ff == ST_DONE) && out_free) || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // record the sample; op 2 and the unused code only query
                  if (req_payload.op == rbe_pkg::OP_RTT) begin
                     rtt_ring_ff[rtt_pos_ff] <= req_payload.rtt_us;
                     rtt_pos_ff <= next_idx(rtt_pos_ff);
                     if (rtt_seen_ff < 2'd2) begin
                        rtt_seen_ff <= rtt_seen_ff + 2'd1;
                     end
                  end else if (req_payload.op == rbe_pkg::OP_THRU) begin
                     bytes_ring_ff[bw_pos_ff] <= req_payload.byte_count;
                     time_ring_ff[bw_pos_ff]  <= req_payload.timestamp_us;
                     bw_pos_ff <= next_idx(bw_pos_ff);
                  end
                  idx_ff   <= '0;
                  state_ff <= ST_EMA;
               end
            end
            ST_EMA: begin
               // walk the ring from slot 0 through the shared average step
               ema_ff <= (idx_ff == '0) ? rtt_ring_ff[idx_ff] : ema_in;
               idx_ff <= next_idx(idx_ff);
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_NEWEST;
               end
            end
            ST_NEWEST: begin
               bytes_a_ff <= bytes_ring_ff[newest];
               time_a_ff  <= time_ring_ff[newest];
               state_ff   <= ST_OLDER;
            end
            ST_OLDER: begin
               bsum_ff  <= {1'b0, bytes_a_ff} + {1'b0, bytes_ring_ff[older]};
               dt_ff    <= time_a_ff - time_ring_ff[older];
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               num_ff <= num_in;
               if (bw_default) begin
                  bw_ff    <= rbe_pkg::BW_DEFAULT;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_res.done) begin
                  bw_ff    <= div_res.quotient;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_ff.srtt_us       <= (rtt_seen_ff == '0) ? rbe_pkg::RTT_DEFAULT
                                                              : ema_ff;
                  rsp_ff.bandwidth_bps <= bw_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/rbe_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rbe_pkg for widths and the command/result structs.
module rbe_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rbe_pkg::div_cmd_type cmd,
   output rbe_pkg::div_res_type res
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [rbe_pkg::DIV_CNT_W-1:0]  count_ff;
   logic [rbe_pkg::DIVISOR_W:0]    rem_ff;
   logic [rbe_pkg::DIVIDEND_W-1:0] quo_ff;
   logic [rbe_pkg::DIVISOR_W-1:0]  dvs_ff;

   logic [rbe_pkg::DIVISOR_W:0] trial;
   logic [rbe_pkg::DIVISOR_W:0] dvs_ext;
   logic                        fits;
   logic [rbe_pkg::DIVISOR_W:0] rem_in;
   logic                        last_bit;

   always_comb begin
      trial    = {rem_ff[rbe_pkg::DIVISOR_W-1:0], quo_ff[rbe_pkg::DIVIDEND_W-1]};
      dvs_ext  = {1'b0, dvs_ff};
      fits     = (trial >= dvs_ext);
      rem_in   = fits ? (trial - dvs_ext) : trial;
      last_bit = (count_ff == rbe_pkg::DIV_CNT_W'(rbe_pkg::DIVIDEND_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && !cmd.start && last_bit;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (last_bit) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath needs no reset
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= '0;
         quo_ff <= cmd.dividend;
         dvs_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[rbe_pkg::DIVIDEND_W-2:0], fits};
      end
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule
